[sv/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants and types for the BGGR bilinear demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int DEF_MAX_WIDTH = 512;
   localparam int SAMPLE_W      = 8;
   localparam int CFG_W         = 10;
   localparam int ROW_W         = 10;
   localparam int OUT_COL_W     = 9;
   localparam int MAX_HEIGHT    = 1023;
   localparam int MIN_DIM       = 3;
   localparam int MAX_RESULTS   = 6;

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int RSP_TDATA_W   = 48;
   localparam int LINE_W        = 2 * SAMPLE_W;
   localparam int WIN_W         = 3 * SAMPLE_W;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 10'd316;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 10'd208;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;

endpackage

[sv/bbd_ram.sv]
// ----------------------------------------------------------------------------
// bbd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bayer_bilinear_demosaic.sv]
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic of a BGGR Bayer raster into RGB words.
// ----------------------------------------------------------------------------
// One Bayer word is taken per cycle while each word causes at most one RGB
// word and rsp_tready stays high; a word that completes a border centre causes
// more results (two on border rows or columns, four at corners, up to six on
// a 3x3 frame), and new words are still taken until stage 1 and the window
// are both full. The output sequencer emits one RGB word per cycle while
// rsp_tready is high. The two previous rows sit in one RAM of MAX_WIDTH entries,
// read and written once per word; the first result of a word appears after
// it passes stage 1, the window register and the sequencer registers.
module bayer_bilinear_demosaic #(
   parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bbd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bbd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bbd_pkg::SAMPLE_W-1:0]         req_tdata,  // bayer_sample
   input  logic                                 req_tuser,  // frame_start
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // red[7:0], green[15:8], blue[23:16], out_col[32:24], out_row[42:33], zero
   output logic [bbd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast   // run_last
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int EW    = (WW > bbd_pkg::CFG_W) ? WW : bbd_pkg::CFG_W;
   localparam int ROW_W = bbd_pkg::ROW_W;
   localparam int SW    = bbd_pkg::SAMPLE_W;
   localparam int PAD_W = bbd_pkg::RSP_TDATA_W - 3 * SW - bbd_pkg::OUT_COL_W - ROW_W;

   // ---------------------------------------------------------------- registers
   logic [bbd_pkg::CFG_W-1:0] frame_width_ff;
   logic [bbd_pkg::CFG_W-1:0] frame_height_ff;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bbd_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bbd_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr) begin
         case (bbd_pkg::reg_index_type'(csr_paddr[2]))
            bbd_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[bbd_pkg::CFG_W-1:0];
            end
            bbd_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[bbd_pkg::CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (bbd_pkg::reg_index_type'(csr_paddr[2]))
         bbd_pkg::REG_FRAME_WIDTH: begin
            csr_prdata = bbd_pkg::CSR_DATA_W'(frame_width_ff);
         end
         bbd_pkg::REG_FRAME_HEIGHT: begin
            csr_prdata = bbd_pkg::CSR_DATA_W'(frame_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // saturated frame size
   logic [EW-1:0]    fw_ext;
   logic [EW-1:0]    w_ext;
   logic [ROW_W-1:0] h;

   assign fw_ext = EW'(frame_width_ff);

   always_comb begin
      if (fw_ext < EW'(bbd_pkg::MIN_DIM)) begin
         w_ext = EW'(bbd_pkg::MIN_DIM);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_ext = EW'(MAX_WIDTH);
      end else begin
         w_ext = fw_ext;
      end
      if (frame_height_ff < ROW_W'(bbd_pkg::MIN_DIM)) begin
         h = ROW_W'(bbd_pkg::MIN_DIM);
      end else if (frame_height_ff > ROW_W'(bbd_pkg::MAX_HEIGHT)) begin
         h = ROW_W'(bbd_pkg::MAX_HEIGHT);
      end else begin
         h = frame_height_ff;
      end
   end

   // ---------------------------------------------------------------- control
   logic req_accept;
   logic v1_ff, v2_ff, busy_ff;
   logic move1, move2, seq_free, rsp_last, rsp_take;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = busy_ff && rsp_tready;
   assign seq_free   = !busy_ff || (rsp_take && rsp_last);
   assign move2      = v2_ff && seq_free;
   assign move1      = v1_ff && (!v2_ff || move2);
   assign req_tready = !v1_ff || move1;

   // ---------------------------------------------------------------- position
   logic [COL_W-1:0] col_ff, col_in, c_cur;
   logic [ROW_W-1:0] row_ff, row_in, r_cur;
   logic             col_wrap, row_wrap;

   always_comb begin
      c_cur    = req_tuser ? '0 : col_ff;
      r_cur    = req_tuser ? '0 : row_ff;
      col_wrap = (EW'(c_cur) + EW'(1)) >= w_ext;
      row_wrap = ({1'b0, r_cur} + (ROW_W + 1)'(1)) >= {1'b0, h};
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : r_cur + ROW_W'(1);
      end else begin
         col_in = c_cur + COL_W'(1);
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [SW-1:0]                s1_ff;
   logic [COL_W-1:0]             c1_ff;
   logic [ROW_W-1:0]             r1_ff;
   logic                         fwd_ff;
   logic [bbd_pkg::LINE_W-1:0]   fwd_data_ff;
   logic [bbd_pkg::LINE_W-1:0]   rd_data, line_word, wr_data;

   assign line_word = fwd_ff ? fwd_data_ff : rd_data;
   assign wr_data   = {line_word[SW-1:0], s1_ff};

   bbd_ram #(
      .WIDTH (bbd_pkg::LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (move1),
      .wr_addr (c1_ff),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (c_cur),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            v1_ff  <= 1'b1;
            fwd_ff <= move1 && (c_cur == c1_ff);
         end else if (move1) begin
            v1_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         s1_ff       <= req_tdata;
         c1_ff       <= c_cur;
         r1_ff       <= r_cur;
         fwd_data_ff <= wr_data;
      end
   end

   // emit decision for the centre completed by this word
   logic             emit1;
   logic [COL_W-1:0] xx1;
   logic [ROW_W-1:0] yy1;

   assign xx1   = c1_ff - COL_W'(1);
   assign yy1   = r1_ff - ROW_W'(1);
   assign emit1 = (c1_ff >= COL_W'(2)) && (EW'(c1_ff) < w_ext) &&
                  (r1_ff >= ROW_W'(2)) && (r1_ff < h);

   // ---------------------------------------------------------------- window
   logic [bbd_pkg::WIN_W-1:0] window_ff [3];
   logic [COL_W-1:0]          xx2_ff;
   logic [ROW_W-1:0]          yy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         window_ff[0] <= '0;
         window_ff[1] <= '0;
         window_ff[2] <= '0;
      end else begin
         if (move1) begin
            window_ff[0] <= window_ff[1];
            window_ff[1] <= window_ff[2];
            window_ff[2] <= {line_word[2*SW-1:SW], line_word[SW-1:0], s1_ff};
            v2_ff        <= emit1;
         end else if (move2) begin
            v2_ff <= 1'b0;
         end
      end
      if (move1) begin
         xx2_ff <= xx1;
         yy2_ff <= yy1;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic [SW-1:0]    tl, tm, tr, ml, mm, mr, bl, bm, br;
   logic [SW+1:0]    n4_sum, d4_sum;
   logic [SW:0]      hz_sum, vt_sum;
   logic [SW-1:0]    n4, d4, hz, vt;
   logic [SW-1:0]    red_in, green_in, blue_in;
   logic [COL_W-1:0] w_m1, w_m2;
   logic [ROW_W-1:0] h_m1, h_m2;
   logic             col_lo, col_hi, row_lo, row_hi;
   logic [COL_W-1:0] cols_in [3];
   logic [ROW_W-1:0] rows_in [3];

   always_comb begin
      tl = window_ff[0][3*SW-1:2*SW];
      ml = window_ff[0][2*SW-1:SW];
      bl = window_ff[0][SW-1:0];
      tm = window_ff[1][3*SW-1:2*SW];
      mm = window_ff[1][2*SW-1:SW];
      bm = window_ff[1][SW-1:0];
      tr = window_ff[2][3*SW-1:2*SW];
      mr = window_ff[2][2*SW-1:SW];
      br = window_ff[2][SW-1:0];

      n4_sum = (SW + 2)'(ml) + (SW + 2)'(mr) + (SW + 2)'(tm) + (SW + 2)'(bm);
      d4_sum = (SW + 2)'(tl) + (SW + 2)'(tr) + (SW + 2)'(bl) + (SW + 2)'(br);
      hz_sum = (SW + 1)'(ml) + (SW + 1)'(mr);
      vt_sum = (SW + 1)'(tm) + (SW + 1)'(bm);
      n4     = n4_sum[SW+1:2];
      d4     = d4_sum[SW+1:2];
      hz     = hz_sum[SW:1];
      vt     = vt_sum[SW:1];

      case ({yy2_ff[0], xx2_ff[0]})
         2'b11: begin
            red_in = mm;  green_in = n4;  blue_in = d4;
         end
         2'b10: begin
            red_in = hz;  green_in = mm;  blue_in = vt;
         end
         2'b01: begin
            red_in = vt;  green_in = mm;  blue_in = hz;
         end
         default: begin
            red_in = d4;  green_in = n4;  blue_in = mm;
         end
      endcase

      w_m1   = COL_W'(w_ext - EW'(1));
      w_m2   = COL_W'(w_ext - EW'(2));
      h_m1   = h - ROW_W'(1);
      h_m2   = h - ROW_W'(2);
      col_lo = xx2_ff == COL_W'(1);
      col_hi = xx2_ff == w_m2;
      row_lo = yy2_ff == ROW_W'(1);
      row_hi = yy2_ff == h_m2;

      cols_in[0] = col_lo ? '0 : xx2_ff;
      cols_in[1] = col_lo ? xx2_ff : w_m1;
      cols_in[2] = w_m1;
      rows_in[0] = row_lo ? '0 : yy2_ff;
      rows_in[1] = row_lo ? yy2_ff : h_m1;
      rows_in[2] = h_m1;
   end

   // ---------------------------------------------------------------- sequencer
   logic [SW-1:0]    red_ff, green_ff, blue_ff;
   logic [COL_W-1:0] cols_ff [3];
   logic [ROW_W-1:0] rows_ff [3];
   logic [1:0]       nc_ff, nr_ff, i_ff, j_ff;
   logic [2:0]       n_ff;

   assign rsp_last = (n_ff == 3'(bbd_pkg::MAX_RESULTS - 1)) ||
                     ((i_ff == nr_ff - 2'd1) && (j_ff == nc_ff - 2'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (move2) begin
         busy_ff <= 1'b1;
      end else if (rsp_take && rsp_last) begin
         busy_ff <= 1'b0;
      end

      if (move2) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         nc_ff    <= 2'd1 + 2'(col_lo) + 2'(col_hi);
         nr_ff    <= 2'd1 + 2'(row_lo) + 2'(row_hi);
         i_ff     <= '0;
         j_ff     <= '0;
         n_ff     <= '0;
      end else if (rsp_take) begin
         n_ff <= n_ff + 3'd1;
         if (j_ff == nc_ff - 2'd1) begin
            j_ff <= '0;
            i_ff <= i_ff + 2'd1;
         end else begin
            j_ff <= j_ff + 2'd1;
         end
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = rsp_last;
   assign rsp_tdata  = {{PAD_W{1'b0}},
                        rows_ff[i_ff],
                        bbd_pkg::OUT_COL_W'(cols_ff[j_ff]),
                        blue_ff, green_ff, red_ff};

endmodule
